// ===== rtl/tacf_pkg.sv =====
// ----------------------------------------------------------------------------
// tacf_pkg: shared types and tables of the tilt angle block
// Sample and result item types, the data word handed from cell to cell, and
// the sine and cosine tables for whole degrees 0 to 90 in unsigned Q2.62.
// ----------------------------------------------------------------------------
`default_nettype none

package tacf_pkg;

  // Sample width and the width of a sample magnitude (up to 2^(SAMPLE_BITS-1)).
  localparam int SAMPLE_BITS  = 16;
  localparam int MAG_W        = SAMPLE_BITS;
  localparam int ANGLE_W      = 8;

  // Angle search: whole degrees 0..RIGHT_DEG, one bit decided per cell.
  localparam int RIGHT_DEG       = 90;
  localparam int HALF_CIRCLE_DEG = 180;
  localparam int DEG_W           = $clog2(RIGHT_DEG + 1);
  localparam int NUM_CELLS       = DEG_W;

  // Series length used to build the tables.
  localparam int ANGLE_STAGES = 20;

  // Table format: unsigned Q2.62, split into halves for the multipliers.
  localparam int TRIG_W  = 64;
  localparam int HALF_W  = TRIG_W / 2;
  localparam int PROD_W  = MAG_W + HALF_W;
  localparam int CMP_W   = MAG_W + TRIG_W;

  localparam logic [TRIG_W-1:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [TRIG_W-1:0] PI_Q62  = 64'hC90F_DAA2_2168_C234;

  typedef logic [RIGHT_DEG:0][TRIG_W-1:0] trig_tab_t;

  // Input item.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] tilt_sample;
    logic signed [SAMPLE_BITS-1:0] reference_sample;
  } tilt_in_t;

  // Result item.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_degrees;
    logic                      angle_valid;
  } tilt_out_t;

  // Data word that travels down the chain of cells.
  typedef struct packed {
    logic             neg;      // tilt sample is negative
    logic             nonzero;  // at least one sample is nonzero
    logic [MAG_W-1:0] mag_a;    // tilt magnitude
    logic [MAG_W-1:0] mag_b;    // reference magnitude
    logic [DEG_W-1:0] deg;      // angle bits decided so far
  } cell_data_t;

  // Build the sine (want_sin = 1) or cosine table at elaboration. The series
  // is summed for 0..45 degrees and mirrored for 46..90; 0 is exact, and 45 gets equal sine and cosine.
  function automatic trig_tab_t build_tab(input logic want_sin);
    trig_tab_t          tab;
    logic [TRIG_W-1:0]  step;
    logic [TRIG_W-1:0]  x;
    logic [TRIG_W-1:0]  term;
    logic [TRIG_W-1:0]  s;
    logic [TRIG_W-1:0]  c;
    logic [2*TRIG_W-1:0] prod;
    logic [1:0]         phase;
    int                 k;
    int                 n;
    tab  = '0;
    step = PI_Q62 / 64'(HALF_CIRCLE_DEG);
    for (k = 0; k <= RIGHT_DEG / 2; k++) begin
      x    = step * 64'(k);
      term = x;
      s    = x;
      c    = ONE_Q62;
      for (n = 2; n <= 2 * ANGLE_STAGES; n++) begin
        prod  = {64'd0, term} * {64'd0, x};
        term  = prod[125:62] / 64'(n);
        phase = 2'(n);
        case (phase)
          2'd0:    c = c + term;
          2'd1:    s = s + term;
          2'd2:    c = c - term;
          default: s = s - term;
        endcase
      end
      if (k == 0) begin
        s = '0;
        c = ONE_Q62;
      end
      if (k == RIGHT_DEG / 2) begin
        c = s;
      end
      if (want_sin) begin
        tab[k]             = s;
        tab[RIGHT_DEG - k] = c;
      end else begin
        tab[k]             = c;
        tab[RIGHT_DEG - k] = s;
      end
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_tab(1'b1);
  localparam trig_tab_t COS_TAB = build_tab(1'b0);

endpackage

`default_nettype wire

// ===== rtl/tacf_front.sv =====
// ----------------------------------------------------------------------------
// tacf_front: sample magnitudes
// Registers the magnitudes of both samples, the tilt sign and the
// both-zero flag, and starts the chain with no angle bits decided.
// ----------------------------------------------------------------------------
`default_nettype none

module tacf_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire tacf_pkg::tilt_in_t  item_i,
  output logic                     valid_o,
  output tacf_pkg::cell_data_t     data_o
);

  logic                          valid_q;
  tacf_pkg::cell_data_t          data_d;
  tacf_pkg::cell_data_t          data_q;
  logic [tacf_pkg::MAG_W-1:0]    raw_a;
  logic [tacf_pkg::MAG_W-1:0]    raw_b;

  // Two's complement magnitudes; the most negative value maps to 2^(N-1).
  always_comb begin
    raw_a          = tacf_pkg::MAG_W'(item_i.tilt_sample);
    raw_b          = tacf_pkg::MAG_W'(item_i.reference_sample);
    data_d.neg     = raw_a[tacf_pkg::MAG_W-1];
    data_d.mag_a   = raw_a[tacf_pkg::MAG_W-1] ? (~raw_a + 1'b1) : raw_a;
    data_d.mag_b   = raw_b[tacf_pkg::MAG_W-1] ? (~raw_b + 1'b1) : raw_b;
    data_d.nonzero = (raw_a != '0) || (raw_b != '0);
    data_d.deg     = '0;
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/tacf_cell.sv =====
// ----------------------------------------------------------------------------
// tacf_cell: one angle bit
// Tries to set one bit of the angle. The first stage looks up sine and
// cosine of the trial angle and forms the partial products; the second
// stage keeps the bit if trial <= 90 and the assembled |a|*cos >= |b|*sin.
// ----------------------------------------------------------------------------
`default_nettype none

module tacf_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [$clog2(tacf_pkg::DEG_W)-1:0] bit_i,
  input  wire logic                         valid_i,
  input  wire tacf_pkg::cell_data_t         data_i,
  output logic                              valid_o,
  output tacf_pkg::cell_data_t              data_o
);

  localparam int DW = tacf_pkg::DEG_W;
  localparam int HW = tacf_pkg::HALF_W;
  localparam int PW = tacf_pkg::PROD_W;
  localparam int CW = tacf_pkg::CMP_W;

  logic [DW-1:0]              trial;
  logic                       in_range;
  logic [DW-1:0]              idx;
  logic [tacf_pkg::TRIG_W-1:0] cos_v;
  logic [tacf_pkg::TRIG_W-1:0] sin_v;

  logic                       valid1_q;
  tacf_pkg::cell_data_t       data1_q;
  logic [DW-1:0]              trial_q;
  logic                       in_range_q;
  logic [PW-1:0]              pc_hi_q;
  logic [PW-1:0]              pc_lo_q;
  logic [PW-1:0]              ps_hi_q;
  logic [PW-1:0]              ps_lo_q;

  logic [CW-1:0]              lhs;
  logic [CW-1:0]              rhs;
  tacf_pkg::cell_data_t       data2_d;
  logic                       valid2_q;
  tacf_pkg::cell_data_t       data2_q;

  // Trial angle and table lookup; angles past 90 degrees are never kept.
  always_comb begin
    trial    = data_i.deg | (DW'(1) << bit_i);
    in_range = (trial <= DW'(tacf_pkg::RIGHT_DEG));
    idx      = in_range ? trial : DW'(tacf_pkg::RIGHT_DEG);
    cos_v    = tacf_pkg::COS_TAB[idx];
    sin_v    = tacf_pkg::SIN_TAB[idx];
  end

  // Stage one: partial products, each magnitude times a table half.
  always_ff @(posedge clk_i) begin
    data1_q    <= data_i;
    trial_q    <= trial;
    in_range_q <= in_range;
    pc_hi_q    <= PW'(data_i.mag_a) * PW'(cos_v[2*HW-1:HW]);
    pc_lo_q    <= PW'(data_i.mag_a) * PW'(cos_v[HW-1:0]);
    ps_hi_q    <= PW'(data_i.mag_b) * PW'(sin_v[2*HW-1:HW]);
    ps_lo_q    <= PW'(data_i.mag_b) * PW'(sin_v[HW-1:0]);
  end

  // Stage two: full products and the decision on this bit.
  always_comb begin
    lhs     = {pc_hi_q, HW'(0)} + CW'(pc_lo_q);
    rhs     = {ps_hi_q, HW'(0)} + CW'(ps_lo_q);
    data2_d = data1_q;
    if (in_range_q && (lhs >= rhs)) begin
      data2_d.deg = trial_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data2_q <= data2_d;
  end

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  assign valid_o = valid2_q;
  assign data_o  = data2_q;

endmodule

`default_nettype wire

// ===== rtl/tilt_angle_from_accel.sv =====
// ----------------------------------------------------------------------------
// tilt_angle_from_accel: incline angle from two accelerometer samples
// Returns atan(a/|b|) in whole degrees, truncated toward zero, from a tilt
// sample a and a reference sample b, using a pipelined chain of bit cells.
// ----------------------------------------------------------------------------
// Usage:
//   An input item (tilt and reference sample) is taken at each rising edge
//   with start high and busy low. busy is always low: the block takes one
//   item every cycle, back to back.
//   Each result item appears on result_o for exactly one cycle with done_o
//   high, in input order.
//   The pipeline holds 16 registers: one magnitude stage, seven angle cells
//   of two stages each (one cell per bit of the 0..90 degree result, each
//   with a table lookup and split 16x32 multipliers, then a wide compare),
//   and one output register.
//   angle_valid is 0, with an angle of 0, when both samples are zero.
//   The receiver cannot stall; results are dropped if it does not take them.
//   Reset clears all valid flags, so no result comes out of a reset pipeline;
//   items in flight at reset are lost. The tables are constant logic and
//   need no initialization.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_angle_from_accel (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire tacf_pkg::tilt_in_t  in_i,
  output logic                     done_o,
  output tacf_pkg::tilt_out_t      result_o
);

  localparam int NC = tacf_pkg::NUM_CELLS;
  localparam int BW = $clog2(tacf_pkg::DEG_W);

  logic                  chain_valid [NC+1];
  tacf_pkg::cell_data_t  chain_data  [NC+1];

  logic                  done_q;
  tacf_pkg::tilt_out_t   result_d;
  tacf_pkg::tilt_out_t   result_q;
  logic signed [tacf_pkg::ANGLE_W-1:0] mag_deg;

  assign busy = 1'b0;

  // Magnitudes and flags.
  tacf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .item_i  (in_i),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  // Chain of cells, most significant angle bit first.
  for (genvar g = 0; g < NC; g++) begin : g_cell
    tacf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bit_i   (BW'(NC - 1 - g)),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // Apply the tilt sign and the both-zero case.
  always_comb begin
    mag_deg = signed'(tacf_pkg::ANGLE_W'(chain_data[NC].deg));
    if (!chain_data[NC].nonzero) begin
      result_d.angle_degrees = '0;
      result_d.angle_valid   = 1'b0;
    end else begin
      result_d.angle_degrees = chain_data[NC].neg ? -mag_deg : mag_deg;
      result_d.angle_valid   = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_valid[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== sim/tilt_angle_from_accel_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_angle_from_accel_tb: self-checking bench for the tilt angle block
// Sends sample pairs through the command port and checks each angle against
// a hand-set value or a bit-exact predictor with its own Q2.62 sine and cosine
// tables. A short table of hand-picked pairs comes first. Random pairs follow,
// with many of them placed right at whole-degree boundaries. Gaps between
// items are random, with some back-to-back bursts and some full drains.
// ----------------------------------------------------------------------------

module tilt_angle_from_accel_tb;

  localparam int LAST_DEG     = 90;
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_LIMIT  = 500;
  localparam int TAIL_CYCLES  = 24;
  localparam int NUM_ROWS     = 23;
  localparam int SERIES_TERMS = 20;
  localparam int MAX_MAG      = 32768;

  // Q2.62 constants: one and pi.
  localparam logic [63:0] ONE_FX = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_FX  = 64'hC90F_DAA2_2168_C234;

  // One row of the directed table. When known is set, the angle and the valid
  // flag are the expected result; otherwise the predictor supplies it.
  typedef struct {
    int tilt;
    int base;
    bit known;
    int angle;
    bit valid;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start  = 1'b0;
  logic                 busy;
  tacf_pkg::tilt_in_t   in_i   = '0;
  logic                 done_o;
  tacf_pkg::tilt_out_t  result_o;

  logic [63:0] sine_tab   [0:LAST_DEG];
  logic [63:0] cosine_tab [0:LAST_DEG];

  tacf_pkg::tilt_out_t angle_q [$];
  stim_row_t directed_rows [NUM_ROWS];

  int failures     = 0;
  int angles_seen  = 0;
  int pairs_sent   = 0;
  int zero_pairs   = 0;
  int edge_pairs   = 0;
  int quiet_cycles = 0;

  tilt_angle_from_accel dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .in_i     (in_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Truncated Q2.62 product.
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Expected angle: the largest whole degree d with |a|*cos(d) >= |b|*sin(d),
  // signed like the tilt sample.
  function automatic tacf_pkg::tilt_out_t predict_incline(logic [15:0] tilt,
                                                          logic [15:0] base);
    tacf_pkg::tilt_out_t res;
    logic [15:0]  mag_a;
    logic [15:0]  mag_b;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [7:0]   deg;
    bit           found;
    mag_a = tilt[15] ? 16'(~tilt + 16'd1) : tilt;
    mag_b = base[15] ? 16'(~base + 16'd1) : base;
    res   = '0;
    if (mag_a == 16'd0 && mag_b == 16'd0) return res;
    deg   = 8'd0;
    found = 1'b0;
    for (int d = LAST_DEG; d > 0; d--) begin
      lhs = {112'd0, mag_a} * {64'd0, cosine_tab[d]};
      rhs = {112'd0, mag_b} * {64'd0, sine_tab[d]};
      if (!found && lhs >= rhs) begin
        found = 1'b1;
        deg   = 8'(d);
      end
    end
    res.angle_degrees = tilt[15] ? -deg : deg;
    res.angle_valid   = 1'b1;
    return res;
  endfunction

  // Sample with a given magnitude (0..32768) and sign; 32768 is always negative.
  function automatic logic [15:0] to_sample(int mag, bit neg);
    if (neg || mag == MAX_MAG) return 16'(-mag);
    return 16'(mag);
  endfunction

  function automatic logic [15:0] extreme_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Present one item and hold it until it is taken, then record its angle.
  task automatic send_item(tacf_pkg::tilt_in_t item, tacf_pkg::tilt_out_t want);
    in_i  <= item;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    angle_q.push_back(want);
    pairs_sent++;
    if (item == '0) zero_pairs++;
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop sending until every outstanding angle has come back.
  task automatic drain_angles();
    start <= 1'b0;
    @(posedge clk_i);
    while (angle_q.size() != 0) @(posedge clk_i);
  endtask

  // Result checker and watchdog. Values are sampled at the edge before the
  // block's own updates land, so ordering within the step does not matter.
  always @(posedge clk_i) begin : check_angles
    tacf_pkg::tilt_out_t want;
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done_o) begin
        angles_seen++;
        if (angle_q.size() == 0) begin
          $error("angle result with no item outstanding: %0d valid %0b",
                 result_o.angle_degrees, result_o.angle_valid);
          failures++;
        end else begin
          want = angle_q.pop_front();
          if (result_o.angle_degrees !== want.angle_degrees) begin
            $error("angle_degrees: expected %0d, actual %0d",
                   want.angle_degrees, result_o.angle_degrees);
            failures++;
          end
          if (result_o.angle_valid !== want.angle_valid) begin
            $error("angle_valid: expected %0b, actual %0b",
                   want.angle_valid, result_o.angle_valid);
            failures++;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles, %0d angles outstanding",
                 QUIET_LIMIT, angle_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0]  step;
    logic [63:0]  x;
    logic [63:0]  term;
    logic [63:0]  s;
    logic [63:0]  c;
    logic [127:0] num;
    logic [127:0] quot;
    logic [16:0]  mag_b;
    tacf_pkg::tilt_in_t  item;
    tacf_pkg::tilt_out_t want;
    int           mag_a;
    int           deg;
    bit           burst;

    // Sine and cosine tables: power series over 0..45 degrees, mirrored above.
    step = PI_FX / 64'd180;
    for (int k = 0; k <= LAST_DEG / 2; k++) begin
      x    = step * 64'(k);
      term = x;
      s    = x;
      c    = ONE_FX;
      for (int n = 2; n <= 2 * SERIES_TERMS; n++) begin
        term = fx_mul(term, x) / 64'(n);
        case (n % 4)
          0:       c = c + term;
          1:       s = s + term;
          2:       c = c - term;
          default: s = s - term;
        endcase
      end
      if (k == 0) begin
        s = '0;
        c = ONE_FX;
      end
      if (k == LAST_DEG / 2) c = s;
      sine_tab[k]              = s;
      cosine_tab[k]            = c;
      sine_tab[LAST_DEG - k]   = c;
      cosine_tab[LAST_DEG - k] = s;
    end

    // Directed pairs: zeros, right angles, 45 degree ties, extreme samples.
    directed_rows = '{
      '{0,      0,      1, 0,   0},
      '{1,      0,      1, 90,  1},
      '{-1,     0,      1, -90, 1},
      '{32767,  0,      1, 90,  1},
      '{-32768, 0,      1, -90, 1},
      '{0,      1,      1, 0,   1},
      '{0,      -32768, 1, 0,   1},
      '{0,      32767,  1, 0,   1},
      '{5,      5,      1, 45,  1},
      '{5,      -5,     1, 45,  1},
      '{-5,     5,      1, -45, 1},
      '{32767,  32767,  1, 45,  1},
      '{-32768, -32768, 1, -45, 1},
      '{-32768, 32767,  0, 0,   0},
      '{32767,  -32768, 0, 0,   0},
      '{1,      32767,  0, 0,   0},
      '{-1,     -32768, 0, 0,   0},
      '{32767,  1,      0, 0,   0},
      '{-32768, 1,      0, 0,   0},
      '{100,    173,    0, 0,   0},
      '{-173,   100,    0, 0,   0},
      '{12345,  -6789,  0, 0,   0},
      '{-21846, 21845,  0, 0,   0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      item.tilt_sample      = 16'(directed_rows[i].tilt);
      item.reference_sample = 16'(directed_rows[i].base);
      if (directed_rows[i].known) begin
        want.angle_degrees = 8'(directed_rows[i].angle);
        want.angle_valid   = directed_rows[i].valid;
      end else begin
        want = predict_incline(item.tilt_sample, item.reference_sample);
      end
      send_item(item, want);
      idle_for(i % 3 == 0 ? $urandom_range(0, 15) : 0);
    end
    drain_angles();

    // Random pairs. Many sit within a count or two of a whole-degree boundary,
    // where truncation is decided by the last bits of the tables.
    burst = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          deg   = $urandom_range(1, LAST_DEG - 1);
          mag_b = 17'($urandom_range(1, 32767));
          do begin
            num  = {111'd0, mag_b} * {64'd0, sine_tab[deg]};
            quot = num / {64'd0, cosine_tab[deg]};
            if (quot > 128'(MAX_MAG)) mag_b = mag_b >> 1;
          end while (quot > 128'(MAX_MAG));
          mag_a = int'(quot) + $urandom_range(0, 4) - 2;
          if (mag_a < 0) mag_a = 0;
          if (mag_a > MAX_MAG) mag_a = MAX_MAG;
          item.tilt_sample      = to_sample(mag_a, $urandom_range(0, 1));
          item.reference_sample = to_sample(int'(mag_b), $urandom_range(0, 1));
          edge_pairs++;
        end
        4, 5: begin
          item = tacf_pkg::tilt_in_t'($urandom());
        end
        6, 7: begin
          item.tilt_sample      = 16'($urandom_range(0, 16) - 8);
          item.reference_sample = 16'($urandom_range(0, 16) - 8);
        end
        8: begin
          mag_a = $urandom_range(0, MAX_MAG);
          case ($urandom_range(0, 2))
            0: begin
              item.tilt_sample      = to_sample(mag_a, $urandom_range(0, 1));
              item.reference_sample = '0;
            end
            1: begin
              item.tilt_sample      = '0;
              item.reference_sample = to_sample(mag_a, $urandom_range(0, 1));
            end
            default: begin
              item.tilt_sample      = to_sample(mag_a, $urandom_range(0, 1));
              item.reference_sample = to_sample(mag_a, $urandom_range(0, 1));
            end
          endcase
        end
        default: begin
          item.tilt_sample      = extreme_sample();
          item.reference_sample = extreme_sample();
        end
      endcase
      send_item(item, predict_incline(item.tilt_sample, item.reference_sample));
      if ($urandom_range(0, 249) == 0) drain_angles();
      else idle_for(burst ? 0 : $urandom_range(0, 15));
    end

    // Wind down: let the pipeline empty, then watch for stray results.
    drain_angles();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d sample pairs (%0d directed), %0d near a degree boundary,",
             pairs_sent, NUM_ROWS, edge_pairs);
    $display("%0d with both samples zero; %0d angles came back and were compared.",
             zero_pairs, angles_seen);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
